### rtl/knp_pkg.sv
// Shared types, constants and codes for the knapsack solution tracker.
package knp_pkg;

    localparam int ITEMS_DEF = 256;
    localparam int DIMS_DEF  = 8;

    localparam int CMD_W  = 3;
    localparam int ITEM_W = 8;
    localparam int DIM_W  = 3;
    localparam int VAL_W  = 32;
    localparam int OBJ_W  = 40;
    localparam int REM_W  = 42;
    localparam int STAT_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_PROFIT = 3'd0,
        CMD_LOAD_WEIGHT = 3'd1,
        CMD_LOAD_CAP    = 3'd2,
        CMD_CLEAR       = 3'd3,
        CMD_ADD         = 3'd4,
        CMD_REMOVE      = 3'd5,
        CMD_FLIP        = 3'd6
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_ALREADY = 2'd1,
        ST_NOT_SEL = 2'd2
    } status_t;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [ITEM_W-1:0] item_index;
        logic [DIM_W-1:0]  dimension_index;
        logic [VAL_W-1:0]  load_value;
    } req_t;

    typedef struct packed {
        logic [OBJ_W-1:0]  objective;
        logic              is_feasible;
        logic [STAT_W-1:0] status;
        logic              item_selected;
    } rsp_t;

    typedef struct packed {
        logic [REM_W-1:0] a;
        logic [VAL_W-1:0] b;
        logic             sub;
    } alu_op_t;

endpackage

### rtl/knapsack_solution_tracker_top.sv
// Top level of the knapsack solution tracker: sequencer, tables and shared adder.
//
// A transaction is accepted at a rising edge where start is high and busy is low.
// The request struct carries the command, item index, dimension index and load value.
// Every transaction produces exactly one result, shown on result for one cycle while
// result_valid is high. The receiver cannot stall, so results are never held back.
// Loads and the unused command first decode and write, then read the selection bit, then
// show the result; a new transaction may already be accepted while the result is shown.
// For add, remove and flip the shared adder first updates the objective, then walks the
// remaining-capacity memory one dimension per cycle through its single read and write
// port. An add of a selected item, a remove of an unselected one or an item out of range
// ends after the selection bit is read, with no walk.
// Clear sweeps the selection memory one entry per cycle and copies every capacity into
// its remaining capacity.
// After reset the block is busy while the selection memory is cleared; the objective is
// zero, the remaining capacities read as zero and the solution is feasible. Profit,
// weight and capacity tables hold no value until loaded.
module knapsack_solution_tracker_top #(
    parameter int ITEMS = knp_pkg::ITEMS_DEF,
    parameter int DIMS  = knp_pkg::DIMS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  knp_pkg::req_t request,
    output logic          busy,
    output logic          result_valid,
    output knp_pkg::rsp_t result
);

    localparam int IW         = $clog2(ITEMS);
    localparam int DW         = (DIMS > 1) ? $clog2(DIMS) : 1;
    localparam int ICW        = ((IW > knp_pkg::ITEM_W) ? IW : knp_pkg::ITEM_W) + 1;
    localparam int DCW        = ((DW > knp_pkg::DIM_W) ? DW : knp_pkg::DIM_W) + 1;
    localparam int SWEEP_LAST = (ITEMS > DIMS) ? ITEMS : DIMS;
    localparam int SW         = $clog2(SWEEP_LAST + 1);
    localparam int VAL_W      = knp_pkg::VAL_W;
    localparam int OBJ_W      = knp_pkg::OBJ_W;
    localparam int REM_W      = knp_pkg::REM_W;
    localparam int STAT_W     = knp_pkg::STAT_W;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_DECODE,
        S_CHECK,
        S_WALK,
        S_CLEAR
    } state_t;

    state_t              state_reg, state_next;
    knp_pkg::req_t       req_reg, req_next;
    logic [SW-1:0]       cnt_reg, cnt_next;
    logic [OBJ_W-1:0]    obj_reg, obj_next;
    logic                feas_reg, feas_next;
    logic                neg_reg, neg_next;
    logic                add_reg, add_next;
    logic [DIMS-1:0]     rem_valid_reg, rem_valid_next;
    logic                rem_rd_valid_reg;
    logic                cap_pend_reg, cap_pend_next;
    logic [DW-1:0]       cap_addr_reg, cap_addr_next;
    logic                result_valid_reg, result_valid_next;
    knp_pkg::rsp_t       result_reg, result_next;

    logic [ICW-1:0]      item_wide;
    logic [DCW-1:0]      dim_wide;
    logic                item_ok;
    logic                dim_ok;
    logic [IW-1:0]       item_idx;
    logic [DW-1:0]       dim_idx;
    logic [DW-1:0]       walk_dim;
    logic                last_dim;
    logic [DW-1:0]       rd_dim;
    logic                neg_acc;
    logic                fin_sel;
    logic [STAT_W-1:0]   fin_status;

    logic                prof_we;
    logic [VAL_W-1:0]    prof_q;
    logic                w_we;
    logic [VAL_W-1:0]    w_q;
    logic                cap_we;
    logic [VAL_W-1:0]    cap_q;
    logic                sel_we;
    logic [IW-1:0]       sel_waddr;
    logic                sel_wdata;
    logic                sel_q;
    logic                rem_we;
    logic [DW-1:0]       rem_waddr;
    logic [REM_W-1:0]    rem_wdata;
    logic [REM_W-1:0]    rem_q;
    logic [REM_W-1:0]    rem_eff;

    knp_pkg::alu_op_t    alu_op;
    logic [REM_W-1:0]    alu_y;

    assign item_wide = ICW'(req_reg.item_index);
    assign dim_wide  = DCW'(req_reg.dimension_index);
    assign item_ok   = item_wide < ICW'(ITEMS);
    assign dim_ok    = dim_wide < DCW'(DIMS);
    assign item_idx  = item_wide[IW-1:0];
    assign dim_idx   = dim_wide[DW-1:0];
    assign walk_dim  = cnt_reg[DW-1:0];
    assign last_dim  = walk_dim == DW'(DIMS - 1);
    assign rd_dim    = (state_reg == S_WALK && !last_dim) ? walk_dim + 1'b1 : '0;
    assign rem_eff   = rem_rd_valid_reg ? rem_q : '0;
    assign neg_acc   = neg_reg | alu_y[REM_W-1];

    knp_ram #(.AW(IW), .W(VAL_W)) u_profit (
        .clk     (clk),
        .wr_en   (prof_we),
        .wr_addr (item_idx),
        .wr_data (req_reg.load_value),
        .rd_addr (item_idx),
        .rd_data (prof_q)
    );

    knp_ram #(.AW(DW + IW), .W(VAL_W)) u_weight (
        .clk     (clk),
        .wr_en   (w_we),
        .wr_addr ({dim_idx, item_idx}),
        .wr_data (req_reg.load_value),
        .rd_addr ({rd_dim, item_idx}),
        .rd_data (w_q)
    );

    knp_ram #(.AW(DW), .W(VAL_W)) u_capacity (
        .clk     (clk),
        .wr_en   (cap_we),
        .wr_addr (dim_idx),
        .wr_data (req_reg.load_value),
        .rd_addr (cnt_reg[DW-1:0]),
        .rd_data (cap_q)
    );

    knp_ram #(.AW(IW), .W(1)) u_selected (
        .clk     (clk),
        .wr_en   (sel_we),
        .wr_addr (sel_waddr),
        .wr_data (sel_wdata),
        .rd_addr (item_idx),
        .rd_data (sel_q)
    );

    knp_ram #(.AW(DW), .W(REM_W)) u_remaining (
        .clk     (clk),
        .wr_en   (rem_we),
        .wr_addr (rem_waddr),
        .wr_data (rem_wdata),
        .rd_addr (rd_dim),
        .rd_data (rem_q)
    );

    knp_addsub u_addsub (
        .op (alu_op),
        .y  (alu_y)
    );

    always_comb
    begin
        state_next        = state_reg;
        req_next          = req_reg;
        cnt_next          = cnt_reg;
        obj_next          = obj_reg;
        feas_next         = feas_reg;
        neg_next          = neg_reg;
        add_next          = add_reg;
        rem_valid_next    = rem_valid_reg;
        cap_pend_next     = 1'b0;
        cap_addr_next     = cap_addr_reg;
        result_valid_next = 1'b0;
        result_next       = result_reg;
        fin_sel           = 1'b0;
        fin_status        = knp_pkg::ST_OK;

        prof_we   = 1'b0;
        w_we      = 1'b0;
        cap_we    = 1'b0;
        sel_we    = 1'b0;
        sel_waddr = item_idx;
        sel_wdata = 1'b0;
        rem_we    = 1'b0;
        rem_waddr = walk_dim;
        rem_wdata = alu_y;

        alu_op.a   = rem_eff;
        alu_op.b   = w_q;
        alu_op.sub = add_reg;

        if (cap_pend_reg)
        begin
            rem_we    = 1'b1;
            rem_waddr = cap_addr_reg;
            rem_wdata = REM_W'(cap_q);
        end

        case (state_reg)
            S_INIT:
            begin
                sel_we    = 1'b1;
                sel_waddr = cnt_reg[IW-1:0];
                if (cnt_reg == SW'(ITEMS - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    req_next   = request;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (req_reg.command)
                    knp_pkg::CMD_LOAD_PROFIT: prof_we = item_ok;
                    knp_pkg::CMD_LOAD_WEIGHT: w_we    = item_ok && dim_ok;
                    knp_pkg::CMD_LOAD_CAP:    cap_we  = dim_ok;
                    default:                  prof_we = 1'b0;
                endcase
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                alu_op.a   = REM_W'(obj_reg);
                alu_op.b   = prof_q;
                alu_op.sub = sel_q;
                case (req_reg.command)
                    knp_pkg::CMD_CLEAR:
                    begin
                        cnt_next   = '0;
                        state_next = S_CLEAR;
                    end
                    knp_pkg::CMD_ADD, knp_pkg::CMD_REMOVE, knp_pkg::CMD_FLIP:
                    begin
                        if (!item_ok)
                        begin
                            result_valid_next = 1'b1;
                        end
                        else if (req_reg.command == knp_pkg::CMD_ADD && sel_q)
                        begin
                            fin_sel           = 1'b1;
                            fin_status        = knp_pkg::ST_ALREADY;
                            result_valid_next = 1'b1;
                        end
                        else if (req_reg.command == knp_pkg::CMD_REMOVE && !sel_q)
                        begin
                            fin_status        = knp_pkg::ST_NOT_SEL;
                            result_valid_next = 1'b1;
                        end
                        else
                        begin
                            obj_next   = alu_y[OBJ_W-1:0];
                            sel_we     = 1'b1;
                            sel_wdata  = !sel_q;
                            add_next   = !sel_q;
                            neg_next   = 1'b0;
                            cnt_next   = '0;
                            state_next = S_WALK;
                        end
                    end
                    default:
                    begin
                        fin_sel           = item_ok && sel_q;
                        result_valid_next = 1'b1;
                    end
                endcase
            end
            S_WALK:
            begin
                rem_we    = 1'b1;
                rem_waddr = walk_dim;
                rem_wdata = alu_y;
                if (last_dim)
                begin
                    feas_next         = add_reg ? (feas_reg && !neg_acc) : !neg_acc;
                    fin_sel           = add_reg;
                    result_valid_next = 1'b1;
                end
                else
                begin
                    neg_next = neg_acc;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_CLEAR:
            begin
                sel_we        = cnt_reg < SW'(ITEMS);
                sel_waddr     = cnt_reg[IW-1:0];
                cap_pend_next = cnt_reg < SW'(DIMS);
                cap_addr_next = cnt_reg[DW-1:0];
                if (cnt_reg == SW'(SWEEP_LAST))
                begin
                    obj_next          = '0;
                    feas_next         = 1'b1;
                    result_valid_next = 1'b1;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (rem_we)
        begin
            rem_valid_next[rem_waddr] = 1'b1;
        end

        if (result_valid_next)
        begin
            state_next                = S_IDLE;
            cnt_next                  = '0;
            result_next.objective     = obj_next;
            result_next.is_feasible   = feas_next;
            result_next.status        = fin_status;
            result_next.item_selected = fin_sel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_INIT;
            req_reg          <= '0;
            cnt_reg          <= '0;
            obj_reg          <= '0;
            feas_reg         <= 1'b1;
            neg_reg          <= 1'b0;
            add_reg          <= 1'b0;
            rem_valid_reg    <= '0;
            rem_rd_valid_reg <= 1'b0;
            cap_pend_reg     <= 1'b0;
            cap_addr_reg     <= '0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            req_reg          <= req_next;
            cnt_reg          <= cnt_next;
            obj_reg          <= obj_next;
            feas_reg         <= feas_next;
            neg_reg          <= neg_next;
            add_reg          <= add_next;
            rem_valid_reg    <= rem_valid_next;
            rem_rd_valid_reg <= rem_valid_reg[rd_dim];
            cap_pend_reg     <= cap_pend_next;
            cap_addr_reg     <= cap_addr_next;
            result_valid_reg <= result_valid_next;
            result_reg       <= result_next;
        end
    end

    assign busy         = state_reg != S_IDLE;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

### rtl/knp_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
module knp_ram #(
    parameter int AW = 8,
    parameter int W  = 32
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [W-1:0]  wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [W-1:0]  rd_data
);

    logic [W-1:0] mem [1<<AW];
    logic [W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/knp_addsub.sv
// Shared add/subtract unit for the objective and the remaining capacities.
module knp_addsub (
    input  knp_pkg::alu_op_t               op,
    output logic [knp_pkg::REM_W-1:0]      y
);

    logic [knp_pkg::REM_W-1:0] b_ext;

    assign b_ext = knp_pkg::REM_W'(op.b);
    assign y     = op.sub ? (op.a - b_ext) : (op.a + b_ext);

endmodule

### rtl/knp_checker.sv
// Port-level assertions for the knapsack solution tracker and their bind.
module knp_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input knp_pkg::req_t request,
    input logic          busy,
    input logic          result_valid,
    input knp_pkg::rsp_t result
);

    // Results never appear back to back.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("Two results in consecutive cycles.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("Block not busy after accepting a transaction.");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (!busy && $past(busy)))
        else $error("Result shown outside the end of a transaction.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.status != knp_pkg::ST_OK) |->
        (result.item_selected == (result.status == knp_pkg::ST_ALREADY)))
        else $error("Error status disagrees with the selection bit.");

endmodule

bind knapsack_solution_tracker_top knp_checker u_knp_checker (.*);
